@@ rtl/dth_pkg.sv @@
package dth_pkg;

  localparam int NUM_DAYS = 30;
  localparam int DAY_W    = 5;
  localparam int AMT_W    = 16;
  localparam int TOT_W    = 32;
  localparam int IDX_W    = (NUM_DAYS > 1) ? $clog2(NUM_DAYS) : 1;

  localparam logic KIND_RECORD    = 1'b0;
  localparam logic KIND_END       = 1'b1;
  localparam logic RESULT_DAY     = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [DAY_W-1:0] bin_day;
    logic [AMT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [DAY_W-1:0] out_day;
    logic [TOT_W-1:0] out_total;
    logic             last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUMMARY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rec_wr;
    logic scan_start;
    logic sel_scan;
    logic scan_step;
    logic emit_day;
    logic emit_sum;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic entry_nonzero;
    logic out_free;
  } status_t;

endpackage

@@ rtl/dth_ctrl.sv @@
module dth_ctrl import dth_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   step;

  // A bin with a zero total gives no result, so it never waits on the output.
  assign step = status_i.entry_nonzero ? status_i.out_free : 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_kind_i == KIND_END)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (step && status_i.scan_last) state_d = ST_SUMMARY;
      end
      ST_SUMMARY: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.rec_wr      = in_valid_i && (in_kind_i == KIND_RECORD);
        cmd_o.scan_start  = in_valid_i && (in_kind_i == KIND_END);
      end
      ST_SCAN: begin
        cmd_o.sel_scan  = 1'b1;
        cmd_o.scan_step = step;
        cmd_o.emit_day  = step && status_i.entry_nonzero;
      end
      ST_SUMMARY: begin
        cmd_o.emit_sum = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/dth_datapath.sv @@
module dth_datapath import dth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [TOT_W-1:0] totals_q [NUM_DAYS];
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [TOT_W-1:0] best_total_q, best_total_d;
  logic [DAY_W-1:0] best_day_q, best_day_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             rec_ok;
  logic [DAY_W-1:0] day_m1;
  logic [IDX_W-1:0] rec_idx, rd_idx;
  logic [TOT_W-1:0] rd_data, sat_sum;
  logic [TOT_W:0]   sum;
  logic [DAY_W-1:0] scan_day;
  logic             scan_last;

  // Days are numbered from one; day zero and days past the last are dropped.
  assign rec_ok  = (in_item_i.bin_day != '0) && (in_item_i.bin_day <= DAY_W'(NUM_DAYS));
  assign day_m1  = in_item_i.bin_day - DAY_W'(1);
  assign rec_idx = rec_ok ? day_m1[IDX_W-1:0] : '0;
  assign rd_idx  = cmd_i.sel_scan ? scan_idx_q : rec_idx;
  assign rd_data = totals_q[rd_idx];

  assign sum     = {1'b0, rd_data} + (TOT_W+1)'(in_item_i.amount);
  assign sat_sum = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

  assign scan_day  = DAY_W'(scan_idx_q) + DAY_W'(1);
  assign scan_last = (scan_idx_q == IDX_W'(NUM_DAYS - 1));

  assign status_o.scan_last     = scan_last;
  assign status_o.entry_nonzero = (rd_data != '0);
  assign status_o.out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    scan_idx_d   = scan_idx_q;
    best_total_d = best_total_q;
    best_day_d   = best_day_q;
    if (cmd_i.scan_start) begin
      scan_idx_d   = '0;
      best_total_d = '0;
      best_day_d   = '0;
    end else if (cmd_i.scan_step) begin
      scan_idx_d = scan_last ? '0 : scan_idx_q + IDX_W'(1);
      // Strict compare keeps the earliest day on a tie.
      if (rd_data > best_total_q) begin
        best_total_d = rd_data;
        best_day_d   = scan_day;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.emit_day) begin
      out_valid_d       = 1'b1;
      out_d.result_kind = RESULT_DAY;
      out_d.out_day     = scan_day;
      out_d.out_total   = rd_data;
      out_d.last        = 1'b0;
    end else if (cmd_i.emit_sum) begin
      out_valid_d       = 1'b1;
      out_d.result_kind = RESULT_SUMMARY;
      out_d.out_day     = best_day_q;
      out_d.out_total   = best_total_q;
      out_d.last        = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Each bin is cleared as the scan reads it, leaving the store empty for the next batch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DAYS; i++) totals_q[i] <= '0;
    end else if (cmd_i.scan_step) begin
      totals_q[scan_idx_q] <= '0;
    end else if (cmd_i.rec_wr && rec_ok) begin
      totals_q[rec_idx] <= sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      best_total_q <= '0;
      best_day_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      scan_idx_q   <= scan_idx_d;
      best_total_q <= best_total_d;
      best_day_q   <= best_day_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/daily_total_histogram_argmax.sv @@
// Record transactions are taken one per cycle while idle and update their bin in that
// cycle. An end transaction starts a scan of one bin per cycle while the output is free;
// only a bin with a nonzero total waits on it. Results go to the output register during
// the scan and the summary, and the block takes input again once the summary is loaded.
// Reset is asynchronous and active low; it clears every bin, the argmax and out_valid.
module daily_total_histogram_argmax import dth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences record updates, the bin scan and the summary result.
  dth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the bin totals, the running maximum and the output register.
  dth_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import dth_pkg::*;

  // Longest run of cycles in which neither channel completes a transaction before the
  // run is declared hung. A correct run needs at most a sender gap, the scan of every
  // bin and a receiver stall back to back.
  localparam int HANG_LIMIT  = 2000;
  // Cycles allowed after the last expected result for any stray result to show up.
  localparam int DRAIN_WAIT  = NUM_DAYS + 10;
  // Transactions near the end of the run that are sent and taken without any idling.
  localparam int QUIET_TAIL  = 40;
  localparam int RANDOM_ITEMS = 360;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  daily_total_histogram_argmax dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Transactions waiting to be sent, and the results that the histogram owes us, oldest first.
  in_item_t  pending_items [$];
  out_item_t owed_results [$];

  // Our own copy of the running total of every day.
  logic [TOT_W-1:0] day_sums [NUM_DAYS] = '{default: '0};

  int unsigned fail_count = 0;
  int unsigned in_count = 0;
  int unsigned hang_cycles = 0;

  // Idling happens only outside the closing stretch, and then only in two of every three
  // windows of fifty input transactions, so that long runs at full rate occur as well.
  function automatic logic idle_allowed();
    return (pending_items.size() >= QUIET_TAIL) && ((in_count / 50) % 3 != 0);
  endfunction

  // Works out what one accepted input transaction does to the histogram. A record adds its
  // amount to its day, saturating at the top of the 32-bit range, and is dropped when the
  // day is 0 or beyond the last day. An end transaction reads out every day with a positive
  // total in ascending order, then a summary naming the first day with the greatest total,
  // and leaves every day cleared.
  task automatic predict_histogram(input in_item_t item);
    logic [TOT_W:0]   sum;
    logic [TOT_W-1:0] peak_total;
    logic [DAY_W-1:0] peak_day;
    if (item.kind == KIND_RECORD) begin
      if (item.bin_day >= 1 && item.bin_day <= NUM_DAYS) begin
        sum = {1'b0, day_sums[item.bin_day - 1]} + item.amount;
        day_sums[item.bin_day - 1] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
      end
    end else begin
      peak_total = '0;
      peak_day   = '0;
      for (int d = 0; d < NUM_DAYS; d++) begin
        if (day_sums[d] != '0) begin
          owed_results.push_back('{result_kind: RESULT_DAY, out_day: DAY_W'(d + 1),
                                   out_total: day_sums[d], last: 1'b0});
        end
        // The compare is strict, so on a tie the earlier day keeps the lead.
        if (day_sums[d] > peak_total) begin
          peak_total = day_sums[d];
          peak_day   = DAY_W'(d + 1);
        end
        day_sums[d] = '0;
      end
      owed_results.push_back('{result_kind: RESULT_SUMMARY, out_day: peak_day,
                               out_total: peak_total, last: 1'b1});
    end
  endtask

  task automatic add_item(input logic item_kind, input int day, input int amt);
    pending_items.push_back('{kind: item_kind, bin_day: DAY_W'(day), amount: AMT_W'(amt)});
  endtask

  // Driver. The payload is only changed once the current transaction has been taken, and
  // valid is given a single assignment per edge.
  always @(posedge clk_i) begin
    int unsigned gap;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_histogram(in_item);
        in_count++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
          // A burst of idle cycles of random length, this one included.
          gap = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end
      end
    end
  end

  // Monitor. Outputs are sampled at the edge, before the block updates them, and each
  // completed output transaction is matched field by field against the oldest owed result.
  always @(posedge clk_i) begin
    int unsigned stall;
    out_item_t   want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: result_kind %0d out_day %0d out_total %0d last %0d",
                 out_item_o.result_kind, out_item_o.out_day, out_item_o.out_total,
                 out_item_o.last);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_item_o.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", want.result_kind,
                   out_item_o.result_kind);
            fail_count++;
          end
          if (out_item_o.out_day !== want.out_day) begin
            $error("out_day: expected %0d, actual %0d", want.out_day, out_item_o.out_day);
            fail_count++;
          end
          if (out_item_o.out_total !== want.out_total) begin
            $error("out_total: expected %0d, actual %0d", want.out_total,
                   out_item_o.out_total);
            fail_count++;
          end
          if (out_item_o.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_item_o.last);
            fail_count++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on progress: any transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        hang_cycles = 0;
      end else begin
        hang_cycles++;
      end
      if (hang_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_count;
    int          batch_len;
    int          day;
    int          amt;
    int          hot_day;

    // Directed part. An empty batch must give a bare summary of day 0 and total 0.
    add_item(KIND_END, 0, 0);
    // Days 0 and 31 lie outside the calendar and are dropped; the fields of an end
    // transaction carry no meaning, so all-ones there must change nothing.
    add_item(KIND_RECORD, 0, 'hFFFF);
    add_item(KIND_RECORD, 31, 'hFFFF);
    add_item(KIND_END, 31, 'hFFFF);
    // A zero amount leaves its day at zero, so that day gives no result. Days 15 and 30
    // tie for the greatest total and the earlier one must win.
    add_item(KIND_RECORD, 1, 0);
    add_item(KIND_RECORD, 30, 'hFFFF);
    add_item(KIND_RECORD, 4, 0);
    add_item(KIND_RECORD, 1, 7);
    add_item(KIND_RECORD, 15, 'hFFFF);
    add_item(KIND_RECORD, 2, 1);
    add_item(KIND_END, 0, 0);
    // Alternating bit patterns on the amount field, and repeated hits on the same day.
    add_item(KIND_RECORD, 16, 'h5555);
    add_item(KIND_RECORD, 17, 'hAAAA);
    add_item(KIND_RECORD, 16, 'hAAAA);
    add_item(KIND_RECORD, 10, 'h8000);
    add_item(KIND_RECORD, 21, 'h0001);
    add_item(KIND_RECORD, 31, 'h1234);
    add_item(KIND_END, 16, 'hAAAA);

    // Random batches. Some concentrate on a few days with a narrow set of amounts so
    // that ties for the maximum turn up; a few records fall outside the calendar.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      batch_len = $urandom_range(0, 24);
      hot_day   = $urandom_range(1, NUM_DAYS - 2);
      for (int i = 0; i < batch_len; i++) begin
        case ($urandom_range(0, 9))
          0:       day = ($urandom_range(0, 1) == 0) ? 0 : 31;
          1, 2, 3: day = hot_day + $urandom_range(0, 2);
          default: day = $urandom_range(1, NUM_DAYS);
        endcase
        case ($urandom_range(0, 3))
          0:       amt = $urandom_range(0, 3);
          1:       amt = 'hFFFF;
          default: amt = $urandom_range(0, 'hFFFF);
        endcase
        add_item(KIND_RECORD, day, amt);
      end
      add_item(KIND_END, $urandom_range(0, 31), $urandom_range(0, 'hFFFF));
      random_count += batch_len + 1;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample away from the active edge so that the queues and valid have settled.
    while (pending_items.size() != 0 || in_valid || owed_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
